/* rtl/core/tile_sprite_row_compositor_assert.svh */
// Assertion macros for the tile/sprite row compositor.
// Expects signals clk and rst_n in the scope of use.
`ifndef TILE_SPRITE_ROW_COMPOSITOR_ASSERT_SVH
`define TILE_SPRITE_ROW_COMPOSITOR_ASSERT_SVH

// Combinational implication checked at every clock edge.
`define TSRC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequence checked at the clock after the antecedent.
`define TSRC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/tsrc_pkg.sv */
// Shared types and constants for the tile/sprite row compositor.
// No dependencies.
`default_nettype none

package tsrc_pkg;

    localparam int LANES      = 8;
    localparam int PIX_W      = 8;
    localparam int ROW_W      = LANES * PIX_W;
    localparam int LANE_IDX_W = $clog2(LANES);
    localparam int POS_W      = 12;
    localparam int DIM_W      = 11;
    localparam int PAL_W      = 3;
    localparam int ADDR_W     = 3;
    localparam int DATA_W     = 32;

    localparam logic [LANE_IDX_W-1:0] LANE_MAX = LANE_IDX_W'(LANES - 1);

    localparam logic [PIX_W-1:0] BASE_BG  = 8'd224;
    localparam logic [PIX_W-1:0] BASE_FG  = 8'd240;
    localparam logic [PIX_W-1:0] LOW_MASK = 8'h03;

    localparam logic [DIM_W-1:0] WIDTH_RESET  = 11'd256;
    localparam logic [DIM_W-1:0] HEIGHT_RESET = 11'd240;

    // register index, taken from paddr[2]
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    typedef enum logic [1:0] {
        MODE_BG     = 2'd0,
        MODE_FRONT  = 2'd1,
        MODE_BEHIND = 2'd2
    } mode_t;

    typedef struct packed {
        mode_t              mode;
        logic               flip;
        logic [PIX_W-1:0]   base;
        logic               row_ok;
    } lane_ctl_t;

    typedef struct packed {
        logic [PIX_W-1:0]   pix;
        logic               wr;
    } lane_res_t;

endpackage

`default_nettype wire

/* rtl/core/tsrc_in_if.sv */
// Input channel of the compositor: one tile row plus placement per transfer.
// Depends on tsrc_pkg.
`default_nettype none

interface tsrc_in_if;
    logic                                    valid;
    logic                                    ready;
    logic [1:0]                              mode;
    logic signed [tsrc_pkg::POS_W-1:0]       left_x;
    logic signed [tsrc_pkg::POS_W-1:0]       line_y;
    logic                                    flip_x;
    logic [tsrc_pkg::PAL_W-1:0]              palette;
    logic [tsrc_pkg::ROW_W-1:0]              source_row;
    logic [tsrc_pkg::ROW_W-1:0]              existing_row;

    modport source (
        output valid, mode, left_x, line_y, flip_x, palette, source_row, existing_row,
        input  ready
    );
    modport sink (
        input  valid, mode, left_x, line_y, flip_x, palette, source_row, existing_row,
        output ready
    );
endinterface

`default_nettype wire

/* rtl/core/tsrc_out_if.sv */
// Output channel of the compositor: composited row and lane write mask.
// Depends on tsrc_pkg.
`default_nettype none

interface tsrc_out_if;
    logic                           valid;
    logic                           ready;
    logic [tsrc_pkg::ROW_W-1:0]     new_row;
    logic [tsrc_pkg::LANES-1:0]     write_mask;

    modport source (
        output valid, new_row, write_mask,
        input  ready
    );
    modport sink (
        input  valid, new_row, write_mask,
        output ready
    );
endinterface

`default_nettype wire

/* rtl/core/tsrc_lane.sv */
// One pixel lane: column clip, flip select, transparency and write decision.
// Depends on tsrc_pkg.
`default_nettype none

module tsrc_lane (
    input  wire logic [tsrc_pkg::LANE_IDX_W-1:0]    lane_idx,
    input  wire tsrc_pkg::lane_ctl_t                ctl,
    input  wire logic signed [tsrc_pkg::POS_W-1:0]  left_x,
    input  wire logic [tsrc_pkg::DIM_W-1:0]         screen_width,
    input  wire logic [tsrc_pkg::ROW_W-1:0]         source_row,
    input  wire logic [tsrc_pkg::PIX_W-1:0]         old_pix,
    output tsrc_pkg::lane_res_t                     res
);

    logic [tsrc_pkg::POS_W:0]            col;
    logic                                col_ok;
    logic [tsrc_pkg::LANE_IDX_W-1:0]     sel;
    logic [tsrc_pkg::PIX_W-1:0]          pix;
    logic                                wr_mode;

    // one extra bit so left_x + 7 cannot wrap
    assign col    = {left_x[tsrc_pkg::POS_W-1], left_x}
                  + {{(tsrc_pkg::POS_W + 1 - tsrc_pkg::LANE_IDX_W){1'b0}}, lane_idx};
    assign col_ok = !col[tsrc_pkg::POS_W] && !col[tsrc_pkg::POS_W-1]
                  && (col[tsrc_pkg::DIM_W-1:0] < screen_width);

    assign sel = ctl.flip ? (tsrc_pkg::LANE_MAX - lane_idx) : lane_idx;
    assign pix = source_row[sel * tsrc_pkg::PIX_W +: tsrc_pkg::PIX_W];

    always_comb
    begin
        case (ctl.mode)
            tsrc_pkg::MODE_BG:     wr_mode = 1'b1;
            tsrc_pkg::MODE_FRONT:  wr_mode = (pix != '0);
            tsrc_pkg::MODE_BEHIND: wr_mode = (pix != '0)
                                          && ((old_pix & tsrc_pkg::LOW_MASK) == '0);
            default:               wr_mode = 1'b0;
        endcase
    end

    assign res.wr  = wr_mode && col_ok && ctl.row_ok;
    assign res.pix = pix | ctl.base;

endmodule

`default_nettype wire

/* rtl/core/tsrc_merge.sv */
// Merges lane results with the existing row into the output register.
// Depends on tsrc_pkg and tsrc_out_if.
`default_nettype none

module tsrc_merge (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           load,
    input  wire logic                           in_valid,
    input  wire tsrc_pkg::lane_res_t            lane_res [tsrc_pkg::LANES],
    input  wire logic [tsrc_pkg::ROW_W-1:0]     existing_row,
    tsrc_out_if.source                          row_out
);

    logic                               valid_reg;
    logic [tsrc_pkg::ROW_W-1:0]         row_reg;
    logic [tsrc_pkg::ROW_W-1:0]         row_next;
    logic [tsrc_pkg::LANES-1:0]         mask_reg;
    logic [tsrc_pkg::LANES-1:0]         mask_next;

    always_comb
    begin
        for (int i = 0; i < tsrc_pkg::LANES; i++)
        begin
            mask_next[i] = lane_res[i].wr;
            row_next[i*tsrc_pkg::PIX_W +: tsrc_pkg::PIX_W] = lane_res[i].wr
                ? lane_res[i].pix
                : existing_row[i*tsrc_pkg::PIX_W +: tsrc_pkg::PIX_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && in_valid)
        begin
            row_reg  <= row_next;
            mask_reg <= mask_next;
        end
    end

    assign row_out.valid      = valid_reg;
    assign row_out.new_row    = row_reg;
    assign row_out.write_mask = mask_reg;

endmodule

`default_nettype wire

/* rtl/core/tile_sprite_row_compositor.sv */
// Tile/sprite row compositor, top level.
// Pipeline: an input transfer loads the input stage; the row then moves to the output
// register, from which the sink takes it (input stage, output register).
// Throughput: one row per cycle; eight pixel lanes evaluate a row in parallel; input
// stalls only while the output register holds a row the sink has not taken.
// Reset: rst_n async active low; empties both stages, width = 256, height = 240.
`default_nettype none

module tile_sprite_row_compositor (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [tsrc_pkg::ADDR_W-1:0]    paddr,
    input  wire logic [tsrc_pkg::DATA_W-1:0]    pwdata,
    output logic [tsrc_pkg::DATA_W-1:0]         prdata,
    output logic                                pready,
    tsrc_in_if.sink                             row_in,
    tsrc_out_if.source                          row_out
);

`include "tile_sprite_row_compositor_assert.svh"

    logic [tsrc_pkg::DIM_W-1:0]         width_reg;
    logic [tsrc_pkg::DIM_W-1:0]         height_reg;
    logic                               cfg_wr;

    logic                               adv;
    logic                               s1_valid_reg;
    logic [1:0]                         s1_mode_reg;
    logic signed [tsrc_pkg::POS_W-1:0]  s1_left_x_reg;
    logic signed [tsrc_pkg::POS_W-1:0]  s1_line_y_reg;
    logic                               s1_flip_reg;
    logic [tsrc_pkg::PAL_W-1:0]         s1_pal_reg;
    logic [tsrc_pkg::ROW_W-1:0]         s1_src_reg;
    logic [tsrc_pkg::ROW_W-1:0]         s1_cur_reg;

    tsrc_pkg::mode_t                    s1_mode;
    tsrc_pkg::lane_ctl_t                ctl;
    tsrc_pkg::lane_res_t                lane_res [tsrc_pkg::LANES];
    logic [tsrc_pkg::LANES-1:0]         lane_wr;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= tsrc_pkg::WIDTH_RESET;
            height_reg <= tsrc_pkg::HEIGHT_RESET;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == tsrc_pkg::REG_WIDTH)
            begin
                width_reg <= pwdata[tsrc_pkg::DIM_W-1:0];
            end
            else
            begin
                height_reg <= pwdata[tsrc_pkg::DIM_W-1:0];
            end
        end
    end

    assign prdata = (paddr[2] == tsrc_pkg::REG_HEIGHT)
                  ? {{(tsrc_pkg::DATA_W - tsrc_pkg::DIM_W){1'b0}}, height_reg}
                  : {{(tsrc_pkg::DATA_W - tsrc_pkg::DIM_W){1'b0}}, width_reg};

    // pipeline advances whenever the output register is free or being drained
    assign adv          = !row_out.valid || row_out.ready;
    assign row_in.ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= row_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && row_in.valid)
        begin
            s1_mode_reg   <= row_in.mode;
            s1_left_x_reg <= row_in.left_x;
            s1_line_y_reg <= row_in.line_y;
            s1_flip_reg   <= row_in.flip_x;
            s1_pal_reg    <= row_in.palette;
            s1_src_reg    <= row_in.source_row;
            s1_cur_reg    <= row_in.existing_row;
        end
    end

    // per-row decode shared by all lanes
    assign s1_mode    = tsrc_pkg::mode_t'(s1_mode_reg);
    assign ctl.mode   = s1_mode;
    assign ctl.flip   = s1_flip_reg && (s1_mode != tsrc_pkg::MODE_BG);
    assign ctl.base   = ((s1_mode == tsrc_pkg::MODE_BG) ? tsrc_pkg::BASE_BG : tsrc_pkg::BASE_FG)
                      + {{(tsrc_pkg::PIX_W - tsrc_pkg::PAL_W - 2){1'b0}}, s1_pal_reg, 2'b00};
    assign ctl.row_ok = !s1_line_y_reg[tsrc_pkg::POS_W-1]
                      && (s1_line_y_reg[tsrc_pkg::DIM_W-1:0] < height_reg);

    for (genvar g = 0; g < tsrc_pkg::LANES; g++)
    begin : g_lane
        tsrc_lane u_lane (
            .lane_idx     (tsrc_pkg::LANE_IDX_W'(g)),
            .ctl          (ctl),
            .left_x       (s1_left_x_reg),
            .screen_width (width_reg),
            .source_row   (s1_src_reg),
            .old_pix      (s1_cur_reg[g*tsrc_pkg::PIX_W +: tsrc_pkg::PIX_W]),
            .res          (lane_res[g])
        );
        assign lane_wr[g] = lane_res[g].wr;
    end

    tsrc_merge u_merge (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (adv),
        .in_valid     (s1_valid_reg),
        .lane_res     (lane_res),
        .existing_row (s1_cur_reg),
        .row_out      (row_out)
    );

    `TSRC_ASSERT_NOW(a_stall_cause, !row_in.ready, s1_valid_reg || row_out.valid,
        "input stalled while output register empty")
    `TSRC_ASSERT_NEXT(a_in_to_s1, row_in.valid && row_in.ready, s1_valid_reg,
        "accepted transfer missing from input stage")
    `TSRC_ASSERT_NEXT(a_s1_to_out, s1_valid_reg && adv, row_out.valid,
        "input stage row not moved to output register")
    `TSRC_ASSERT_NOW(a_no_write_clipped_row, s1_valid_reg && !ctl.row_ok, lane_wr == '0,
        "lane writes on a clipped row")

endmodule

`default_nettype wire
